// ===== design/cubic_bezier_point_eval_unit_macros.svh =====
// Assertion macros shared by the cubic Bezier point evaluator.
`ifndef CUBIC_BEZIER_POINT_EVAL_UNIT_MACROS_SVH
`define CUBIC_BEZIER_POINT_EVAL_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define CBE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define CBE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cbe_pkg.sv =====
// Package: widths, constants and shared types of the cubic Bezier evaluator.
`timescale 1ns / 1ps

package cbe_pkg;

    // Field widths
    localparam int COORD_W   = 16;
    localparam int PARAM_W   = 17;

    // Datapath widths per de Casteljau level
    localparam int Q_PROD_W  = COORD_W + PARAM_W;   // level 1 product domain
    localparam int Q_W       = 32;                  // level 1 result, < 2^32
    localparam int R_PROD_W  = Q_W + PARAM_W;       // level 2 product domain
    localparam int R_W       = 48;                  // level 2 result, < 2^48
    localparam int HALF_W    = R_W / 2;             // level 3 split point
    localparam int PP_PROD_W = HALF_W + PARAM_W;    // level 3 partial domain
    localparam int PP_W      = 40;                  // level 3 partials, < 2^40
    localparam int ACC_W     = PP_W + HALF_W;       // final 64-bit sum

    // t == 1.0 in Q1.16, rounding half for the 2^48 scale, bias flip
    localparam logic [PARAM_W-1:0] T_ONE      = 17'h1_0000;
    localparam logic [ACC_W-1:0]   ROUND_HALF = 64'h0000_8000_0000_0000;
    localparam logic [COORD_W-1:0] SIGN_FLIP  = 16'h8000;

    // Config port
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_P0_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_P0_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_P1_X = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_P1_Y = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_P2_X = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_P2_Y = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_P3_X = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_P3_Y = 3'd7;

    // Per-stage load strobes for the axis datapaths
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } cbe_load_t;

    // t and 1-t as seen by each multiply stage
    typedef struct packed {
        logic [PARAM_W-1:0] t1;
        logic [PARAM_W-1:0] u1;
        logic [PARAM_W-1:0] t2;
        logic [PARAM_W-1:0] u2;
        logic [PARAM_W-1:0] t3;
        logic [PARAM_W-1:0] u3;
    } cbe_weights_t;

    // Control points of one axis
    typedef struct packed {
        logic [COORD_W-1:0] c0;
        logic [COORD_W-1:0] c1;
        logic [COORD_W-1:0] c2;
        logic [COORD_W-1:0] c3;
    } cbe_ctrl_pts_t;

endpackage

// ===== design/cbe_regfile.sv =====
// Control point registers on the APB port, plus the registered bounding box.
`timescale 1ns / 1ps

module cbe_regfile
    import cbe_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output cbe_ctrl_pts_t                pts_x,
    output cbe_ctrl_pts_t                pts_y,
    output logic signed [COORD_W-1:0]    box_left,
    output logic signed [COORD_W-1:0]    box_top,
    output logic [COORD_W-1:0]           box_width,
    output logic [COORD_W-1:0]           box_height
);

    logic [COORD_W-1:0]   regs_reg [NUM_REGS];
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    logic signed [COORD_W-1:0] min_x, max_x, min_y, max_y;
    logic signed [COORD_W-1:0] box_left_reg, box_top_reg;
    logic [COORD_W-1:0]        box_width_reg, box_height_reg;

    // Smallest and largest of four signed coordinates
    function automatic logic signed [COORD_W-1:0] min4(input cbe_ctrl_pts_t p);
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        a = ($signed(p.c0) < $signed(p.c1)) ? $signed(p.c0) : $signed(p.c1);
        b = ($signed(p.c2) < $signed(p.c3)) ? $signed(p.c2) : $signed(p.c3);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [COORD_W-1:0] max4(input cbe_ctrl_pts_t p);
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        a = ($signed(p.c0) > $signed(p.c1)) ? $signed(p.c0) : $signed(p.c1);
        b = ($signed(p.c2) > $signed(p.c3)) ? $signed(p.c2) : $signed(p.c3);
        return (a > b) ? a : b;
    endfunction

    // Word index from the byte address
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes, low 16 bits kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '{default: '0};
        end
        else if (wr_en)
        begin
            regs_reg[reg_idx] <= pwdata[COORD_W-1:0];
        end
    end

    // Readback, zero-extended
    assign prdata = {{(APB_DATA_W-COORD_W){1'b0}}, regs_reg[reg_idx]};

    assign pts_x = '{c0: regs_reg[REG_P0_X], c1: regs_reg[REG_P1_X],
                     c2: regs_reg[REG_P2_X], c3: regs_reg[REG_P3_X]};
    assign pts_y = '{c0: regs_reg[REG_P0_Y], c1: regs_reg[REG_P1_Y],
                     c2: regs_reg[REG_P2_Y], c3: regs_reg[REG_P3_Y]};

    // Bounding box of the control points
    always_comb
    begin
        min_x = min4(pts_x);
        max_x = max4(pts_x);
        min_y = min4(pts_y);
        max_y = max4(pts_y);
    end

    // Box is registered from the control point registers, so it trails a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_left_reg   <= '0;
            box_top_reg    <= '0;
            box_width_reg  <= '0;
            box_height_reg <= '0;
        end
        else
        begin
            box_left_reg   <= min_x;
            box_top_reg    <= min_y;
            box_width_reg  <= COORD_W'(max_x - min_x);
            box_height_reg <= COORD_W'(max_y - min_y);
        end
    end

    assign box_left   = box_left_reg;
    assign box_top    = box_top_reg;
    assign box_width  = box_width_reg;
    assign box_height = box_height_reg;

endmodule

// ===== design/cbe_axis_dp.sv =====
// One coordinate axis: three de Casteljau levels plus the final rounding stage.
`timescale 1ns / 1ps

module cbe_axis_dp
    import cbe_pkg::*;
(
    input  logic                       clk,
    input  cbe_load_t                  load,
    input  cbe_weights_t               wgt,
    input  cbe_ctrl_pts_t              pts,
    output logic signed [COORD_W-1:0]  point
);

    logic [COORD_W-1:0] bias [4];
    logic [Q_W-1:0]     q_reg  [3];
    logic [Q_W-1:0]     q_next [3];
    logic [R_W-1:0]     r_reg  [2];
    logic [R_W-1:0]     r_next [2];
    logic [PP_W-1:0]    pp_hi_reg, pp_hi_next;
    logic [PP_W-1:0]    pp_lo_reg, pp_lo_next;
    logic [ACC_W-1:0]   acc;
    logic [COORD_W-1:0] point_reg, point_next;

    // Coordinates biased to unsigned so all products stay unsigned
    assign bias[0] = pts.c0 ^ SIGN_FLIP;
    assign bias[1] = pts.c1 ^ SIGN_FLIP;
    assign bias[2] = pts.c2 ^ SIGN_FLIP;
    assign bias[3] = pts.c3 ^ SIGN_FLIP;

    // Level 1: lerp of control points, scale 2^16
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_next[i] = Q_W'(Q_PROD_W'(bias[i]) * Q_PROD_W'(wgt.u1)
                           + Q_PROD_W'(bias[i+1]) * Q_PROD_W'(wgt.t1));
        end
    end

    // Level 2: scale 2^32
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            r_next[i] = R_W'(R_PROD_W'(q_reg[i]) * R_PROD_W'(wgt.u2)
                           + R_PROD_W'(q_reg[i+1]) * R_PROD_W'(wgt.t2));
        end
    end

    // Level 3, split into upper and lower halves of the level 2 values
    assign pp_hi_next = PP_W'(PP_PROD_W'(r_reg[0][R_W-1:HALF_W]) * PP_PROD_W'(wgt.u3)
                            + PP_PROD_W'(r_reg[1][R_W-1:HALF_W]) * PP_PROD_W'(wgt.t3));
    assign pp_lo_next = PP_W'(PP_PROD_W'(r_reg[0][HALF_W-1:0]) * PP_PROD_W'(wgt.u3)
                            + PP_PROD_W'(r_reg[1][HALF_W-1:0]) * PP_PROD_W'(wgt.t3));

    // Recombine, round to nearest at 2^48, remove bias
    assign acc        = {pp_hi_reg, {HALF_W{1'b0}}} + ACC_W'(pp_lo_reg) + ROUND_HALF;
    assign point_next = acc[ACC_W-1 -: COORD_W] ^ SIGN_FLIP;

    // Stage registers (payload only, no reset)
    always_ff @(posedge clk)
    begin
        if (load.s2)
        begin
            q_reg <= q_next;
        end
        if (load.s3)
        begin
            r_reg <= r_next;
        end
        if (load.s4)
        begin
            pp_hi_reg <= pp_hi_next;
            pp_lo_reg <= pp_lo_next;
        end
        if (load.s5)
        begin
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

endmodule

// ===== design/cubic_bezier_point_eval_unit.sv =====
// Throughput: one word per cycle while the output is not stalled; five register
// stages (parameter, three de Casteljau levels with the last split into partial
// products, rounding).
// A stage holds only while its successor is full and stalled.
// Reset (rst_n low, asynchronous): pipeline emptied, control points and box 0.
`timescale 1ns / 1ps
`include "cubic_bezier_point_eval_unit_macros.svh"

module cubic_bezier_point_eval_unit
    import cbe_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // APB config
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    // Input words
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [PARAM_W-1:0]         curve_param,
    // Result words
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [COORD_W-1:0]  point_x,
    output logic signed [COORD_W-1:0]  point_y,
    output logic signed [COORD_W-1:0]  box_left,
    output logic signed [COORD_W-1:0]  box_top,
    output logic [COORD_W-1:0]         box_width,
    output logic [COORD_W-1:0]         box_height
);

    cbe_ctrl_pts_t pts_x, pts_y;
    cbe_load_t     load;
    cbe_weights_t  wgt;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic ld1;

    logic [PARAM_W-1:0] t_sat, u_sat;
    logic [PARAM_W-1:0] t1_reg, u1_reg, t2_reg, u2_reg, t3_reg, u3_reg;

    assign pready = 1'b1;

    cbe_regfile u_regfile (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pts_x      (pts_x),
        .pts_y      (pts_y),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_width  (box_width),
        .box_height (box_height)
    );

    // Stage ready chain: a stage takes a word when empty or draining
    assign rdy5     = !v5_reg || !out_stall;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    assign ld1    = rdy1 && in_valid;
    assign load.s2 = rdy2 && v1_reg;
    assign load.s3 = rdy3 && v2_reg;
    assign load.s4 = rdy4 && v3_reg;
    assign load.s5 = rdy5 && v4_reg;

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Clamp t to one and form 1-t
    assign t_sat = (curve_param > T_ONE) ? T_ONE : curve_param;
    assign u_sat = T_ONE - t_sat;

    // t / 1-t follow the word down to the last multiply stage
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            t1_reg <= t_sat;
            u1_reg <= u_sat;
        end
        if (load.s2)
        begin
            t2_reg <= t1_reg;
            u2_reg <= u1_reg;
        end
        if (load.s3)
        begin
            t3_reg <= t2_reg;
            u3_reg <= u2_reg;
        end
    end

    assign wgt = '{t1: t1_reg, u1: u1_reg, t2: t2_reg, u2: u2_reg,
                   t3: t3_reg, u3: u3_reg};

    cbe_axis_dp u_axis_x (
        .clk   (clk),
        .load  (load),
        .wgt   (wgt),
        .pts   (pts_x),
        .point (point_x)
    );

    cbe_axis_dp u_axis_y (
        .clk   (clk),
        .load  (load),
        .wgt   (wgt),
        .pts   (pts_y),
        .point (point_y)
    );

    assign out_valid = v5_reg;

    // Input is held off only when every stage is full and the output stalls
    `CBE_ASSERT_IMP(a_stall_only_full, in_stall, v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && out_stall, "input stalled with a free stage")
    // A word in the last multiply stage reaches the output once it is free
    `CBE_ASSERT_NXT(a_s4_advances, v4_reg && rdy5, v5_reg, "stage 4 word lost")
    // A delivered word with nothing behind it leaves the output empty
    `CBE_ASSERT_NXT(a_drain_empty, v5_reg && !out_stall && !v4_reg, !v5_reg, "result repeated")
    // Accepted parameters are never above one after clamping
    `CBE_ASSERT_NXT(a_t_clamped, ld1, (t1_reg <= T_ONE) && (t1_reg + u1_reg == T_ONE), "t out of range")

endmodule
